[sv/pse_pkg.sv]
// Package for the postfix stack evaluator: widths, character codes,
// command and status encodings, and the back-end sequencer types.
// Depends on nothing; every other file of the block imports it.
package pse_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 32;
   localparam int SYM_W       = 8;
   localparam int STATUS_W    = 3;
   localparam int DEPTH_W     = 6;
   localparam int LIMIT_W     = 6;
   localparam int DIGIT_W     = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_STEP_W  = $clog2(DATA_W);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);

   localparam logic [SYM_W-1:0] SYM_HASH    = 8'h23;
   localparam logic [SYM_W-1:0] SYM_ZERO    = 8'h30;
   localparam logic [SYM_W-1:0] SYM_NINE    = 8'h39;
   localparam logic [SYM_W-1:0] SYM_PLUS    = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS   = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_STAR    = 8'h2A;
   localparam logic [SYM_W-1:0] SYM_SLASH   = 8'h2F;
   localparam logic [SYM_W-1:0] SYM_PERCENT = 8'h25;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_FULL    = 3'd1,
      STATUS_EMPTY   = 3'd2,
      STATUS_DIVZERO = 3'd3,
      STATUS_LEFT    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_DIGIT,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_REM,
      OP_END
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [DIGIT_W-1:0] digit;
   } cmd_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_EXEC,
      BS_DIV,
      BS_REFILL,
      BS_DONE
   } back_state_type;

   typedef struct packed {
      logic       take_cmd;
      logic       push;
      logic       set_err;
      status_type err_code;
      logic       commit_alu;
      logic       div_start;
      logic       commit_div;
      logic       refill;
      logic       emit;
   } back_ctrl_type;

endpackage

[sv/pse_if.sv]
// Valid/ready channel interfaces of the postfix stack evaluator: one for
// the character words coming in and one for the result words going out.
// Depends on pse_pkg for the field widths.
interface pse_req_if
   import pse_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

interface pse_rsp_if
   import pse_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   top_value;
   logic [STATUS_W-1:0]        status;
   logic [DEPTH_W-1:0]         depth;
   logic                       is_final;

   modport source (output valid, output top_value, output status, output depth,
                   output is_final, input ready);
   modport sink   (input valid, input top_value, input status, input depth,
                   input is_final, output ready);
endinterface

[sv/postfix_stack_evaluator.sv]
// Top level of the postfix stack evaluator: configuration register, front
// end with its command queue, and the stack back end.
// Depends on pse_pkg, pse_if, pse_front and pse_back.
//
// Usage: each word on req_if carries one ASCII character. Digits push their
// value, + - * / % pop two values and push the 32-bit wrapped result, and
// '#' ends the expression. Every character word produces exactly one word on
// rsp_if with the top of stack, the status, the depth and a final flag; the
// word that answers '#' carries the final result and the stack then clears.
// After an error, characters up to the next '#' are ignored.
// The stack limit is written through csr_write_enable and csr_write_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce; it resets to 20 entries. Items are carried out
// one at a time by the back end: it takes a command and executes it, with a
// refill step after + - * and, for / and %, a radix-2 divider doing one
// quotient bit per cycle and then the refill step, and registers the result
// word; it takes the next command only after that word is written to the
// result register. The front queue keeps taking words in the meantime until
// its four entries are full.
// Reset is synchronous and clears the stack, the error and both channels.
// When the receiver stalls, the result register holds its word and the back
// end waits with the next result, while the queue keeps filling.
module postfix_stack_evaluator
   import pse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data,
   pse_req_if.sink            req_if,
   pse_rsp_if.source          rsp_if
);

   logic [LIMIT_W-1:0] stack_limit_ff;
   logic               cmd_valid;
   cmd_type            cmd;
   logic               cmd_pop;

   // The stack limit register; values above the stack depth act as the depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         stack_limit_ff <= csr_write_data;
      end
   end

   pse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   pse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .stack_limit (stack_limit_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_if      (rsp_if)
   );

   // The back end only takes a command that the queue actually holds.
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> cmd_valid)
      else $error("command taken from an empty queue");

   // A successful final result comes from a stack holding exactly one value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.is_final && rsp_if.status == STATUS_OK)
         |-> rsp_if.depth == DEPTH_W'(1))
      else $error("final result with a wrong depth");

   // The leftover-elements status only answers an end marker.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.is_final) |-> rsp_if.status != STATUS_LEFT)
      else $error("leftover status on a non-final word");

   // The reported depth never exceeds the stack.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> int'(rsp_if.depth) <= STACK_DEPTH)
      else $error("depth beyond the stack");

endmodule

[sv/pse_front.sv]
// Front end: accepts character words, decodes each into a command and
// holds the commands in a short queue for the back end.
// Depends on pse_pkg and pse_if.
module pse_front
   import pse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pse_req_if.sink    req_if,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_pop
);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   cmd_type             decoded;

   function automatic cmd_type decode(input logic [SYM_W-1:0] sym);
      cmd_type c;
      c.digit = DIGIT_W'(sym - SYM_ZERO);
      if (sym == SYM_HASH)                          c.op = OP_END;
      else if (sym >= SYM_ZERO && sym <= SYM_NINE)  c.op = OP_DIGIT;
      else if (sym == SYM_PLUS)                     c.op = OP_ADD;
      else if (sym == SYM_MINUS)                    c.op = OP_SUB;
      else if (sym == SYM_STAR)                     c.op = OP_MUL;
      else if (sym == SYM_SLASH)                    c.op = OP_DIV;
      else if (sym == SYM_PERCENT)                  c.op = OP_REM;
      else                                          c.op = OP_NONE;
      return c;
   endfunction

   assign req_if.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign decoded      = decode(req_if.symbol);
   assign cmd_valid    = (count_ff != '0);
   assign cmd          = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[sv/pse_divider.sv]
// Iterative signed divider: one restoring step per cycle on magnitudes,
// then a sign fix for truncating quotient or remainder.
// Depends on pse_pkg.
module pse_divider
   import pse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   input  logic              want_rem,
   output logic              done,
   output logic [DATA_W-1:0] result
);

   logic [DATA_W-1:0]     rem_ff, quo_ff, ud_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic                  run_ff, done_ff;
   logic                  neg_q_ff, neg_r_ff, rem_sel_ff;
   logic [DATA_W:0]       partial, diff;

   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? DATA_W'(0) - v : v;
   endfunction

   assign partial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = partial - {1'b0, ud_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == DIV_STEP_W'(DATA_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= magnitude(dividend);
         ud_ff      <= magnitude(divisor);
         neg_q_ff   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
         neg_r_ff   <= dividend[DATA_W-1];
         rem_sel_ff <= want_rem;
      end else if (run_ff) begin
         if (!diff[DATA_W]) begin
            rem_ff <= diff[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= partial[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;

   always_comb begin
      if (rem_sel_ff) begin
         result = neg_r_ff ? DATA_W'(0) - rem_ff : rem_ff;
      end else begin
         result = neg_q_ff ? DATA_W'(0) - quo_ff : quo_ff;
      end
   end

endmodule

[sv/pse_back.sv]
// Back end: executes commands on the value stack, with the top two values
// in registers and the rest in a memory, and drives the result register.
// Depends on pse_pkg, pse_if and pse_divider.
module pse_back
   import pse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] stack_limit,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   pse_rsp_if.source          rsp_if
);

   back_state_type    state_ff, state_in;
   back_ctrl_type     ctrl;
   cmd_type           cmd_ff;
   status_type        err_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DATA_W-1:0] top_ff, sec_ff, rd_ff;
   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   logic              has_two, can_push, is_divop, divisor_zero, out_free;
   logic [DATA_W-1:0] alu_result, div_result;
   logic              div_done;

   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    rsp_top_ff, emit_top;
   status_type           rsp_status_ff, emit_status;
   logic [DEPTH_W-1:0]   rsp_depth_ff;
   logic                 rsp_final_ff, emit_final;

   assign has_two      = (count_ff >= CNT_W'(2));
   assign can_push     = (int'(count_ff) < int'(stack_limit)) &&
                         (int'(count_ff) < STACK_DEPTH);
   assign is_divop     = (cmd_ff.op == OP_DIV) || (cmd_ff.op == OP_REM);
   assign divisor_zero = (top_ff == '0);
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign wr_addr      = ADDR_W'(count_ff - CNT_W'(2));
   assign rd_addr      = ADDR_W'(count_ff - CNT_W'(3));

   // top_ff is the top entry, sec_ff the one below it.
   always_comb begin
      case (cmd_ff.op)
         OP_ADD:  alu_result = sec_ff + top_ff;
         OP_SUB:  alu_result = sec_ff - top_ff;
         OP_MUL:  alu_result = DATA_W'(sec_ff * top_ff);
         default: alu_result = sec_ff + top_ff;
      endcase
   end

   pse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (sec_ff),
      .divisor  (top_ff),
      .want_rem (cmd_ff.op == OP_REM),
      .done     (div_done),
      .result   (div_result)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BS_IDLE: begin
            if (cmd_valid) state_in = BS_EXEC;
         end
         BS_EXEC: begin
            if (err_ff == STATUS_OK && has_two &&
                (cmd_ff.op == OP_ADD || cmd_ff.op == OP_SUB || cmd_ff.op == OP_MUL)) begin
               state_in = BS_REFILL;
            end else if (err_ff == STATUS_OK && has_two && is_divop && !divisor_zero) begin
               state_in = BS_DIV;
            end else begin
               state_in = BS_DONE;
            end
         end
         BS_DIV: begin
            if (div_done) state_in = BS_REFILL;
         end
         BS_REFILL: begin
            state_in = BS_DONE;
         end
         BS_DONE: begin
            if (out_free) state_in = BS_IDLE;
         end
         default: state_in = BS_IDLE;
      endcase
   end

   // Control strobes.
   always_comb begin
      ctrl          = '0;
      ctrl.err_code = STATUS_OK;
      case (state_ff)
         BS_IDLE: begin
            ctrl.take_cmd = cmd_valid;
         end
         BS_EXEC: begin
            if (err_ff == STATUS_OK) begin
               case (cmd_ff.op)
                  OP_DIGIT: begin
                     if (can_push) begin
                        ctrl.push = 1'b1;
                     end else begin
                        ctrl.set_err  = 1'b1;
                        ctrl.err_code = STATUS_FULL;
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL: begin
                     if (!has_two) begin
                        ctrl.set_err  = 1'b1;
                        ctrl.err_code = STATUS_EMPTY;
                     end else begin
                        ctrl.commit_alu = 1'b1;
                     end
                  end
                  OP_DIV, OP_REM: begin
                     if (!has_two) begin
                        ctrl.set_err  = 1'b1;
                        ctrl.err_code = STATUS_EMPTY;
                     end else if (divisor_zero) begin
                        ctrl.set_err  = 1'b1;
                        ctrl.err_code = STATUS_DIVZERO;
                     end else begin
                        ctrl.div_start = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BS_DIV: begin
            ctrl.commit_div = div_done;
         end
         BS_REFILL: begin
            ctrl.refill = 1'b1;
         end
         BS_DONE: begin
            ctrl.emit = out_free;
         end
         default: begin
         end
      endcase
   end

   assign cmd_pop = ctrl.take_cmd;

   // Result word for the current command.
   always_comb begin
      emit_final = (cmd_ff.op == OP_END);
      if (emit_final) begin
         if (err_ff != STATUS_OK)          emit_status = err_ff;
         else if (count_ff > CNT_W'(1))    emit_status = STATUS_LEFT;
         else if (count_ff == '0)          emit_status = STATUS_EMPTY;
         else                              emit_status = STATUS_OK;
         emit_top = (emit_status == STATUS_OK) ? top_ff : '0;
      end else begin
         emit_status = err_ff;
         emit_top    = (count_ff == '0) ? '0 : top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         count_ff     <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctrl.push) begin
            count_ff <= count_ff + 1'b1;
         end else if (ctrl.commit_alu || ctrl.commit_div) begin
            count_ff <= count_ff - 1'b1;
         end else if (ctrl.emit && emit_final) begin
            count_ff <= '0;
         end
         if (ctrl.set_err) begin
            err_ff <= ctrl.err_code;
         end else if (ctrl.emit && emit_final) begin
            err_ff <= STATUS_OK;
         end
         if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take_cmd) cmd_ff <= cmd;
      if (ctrl.push) begin
         top_ff <= DATA_W'(cmd_ff.digit);
         sec_ff <= top_ff;
      end else if (ctrl.commit_alu) begin
         top_ff <= alu_result;
      end else if (ctrl.commit_div) begin
         top_ff <= div_result;
      end else if (ctrl.refill && has_two) begin
         sec_ff <= rd_ff;
      end
      if (ctrl.emit) begin
         rsp_top_ff    <= emit_top;
         rsp_status_ff <= emit_status;
         rsp_depth_ff  <= DEPTH_W'(count_ff);
         rsp_final_ff  <= emit_final;
      end
   end

   // Entries below the top two live in the memory at their own index.
   always_ff @(posedge clock) begin
      if (ctrl.push && has_two) begin
         stack_mem[wr_addr] <= sec_ff;
      end
      rd_ff <= stack_mem[rd_addr];
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.top_value = rsp_top_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.depth     = rsp_depth_ff;
   assign rsp_if.is_final  = rsp_final_ff;

endmodule

[test/postfix_stack_evaluator_tb.sv]
// Self-checking testbench for the postfix stack evaluator: directed and random
// character streams against a cycle-free model of the stack, under random stalls.
// Depends on pse_pkg, pse_if and the postfix_stack_evaluator RTL.
module postfix_stack_evaluator_tb;
   import pse_pkg::*;

   // The cycle limit lies well above the slowest legal run, even when
   // every word is a division that waits out receiver stalls.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1300;
   localparam int PHASE_ITEMS  = 160;
   localparam int DRAIN_CYCLES = 40;

   // One expected result word, tagged with the character that caused it so
   // that a mismatch report says which word went wrong.
   typedef struct {
      logic [SYM_W-1:0]    symbol;
      logic [DATA_W-1:0]   top_value;
      status_type          status;
      logic [DEPTH_W-1:0]  depth;
      logic                is_final;
   } result_word_type;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [LIMIT_W-1:0] csr_write_data;

   pse_req_if req_bus ();
   pse_rsp_if rsp_bus ();

   postfix_stack_evaluator u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus)
   );

   // Characters waiting to be driven, and the result words the model has
   // worked out for characters the block already took.
   logic [SYM_W-1:0] char_queue[$];
   result_word_type  expected_results[$];

   // Model copy of the block's state and its stack limit register.
   logic [DATA_W-1:0]  model_stack [STACK_DEPTH];
   int                 stack_fill    = 0;
   status_type         pending_error = STATUS_OK;
   logic [LIMIT_W-1:0] limit_model   = LIMIT_RESET;

   // Stimulus side bookkeeping. The phase limit mirrors the last value written
   // and steers the expression generator; quiet turns all idling off.
   logic [LIMIT_W-1:0] phase_limit = LIMIT_RESET;
   logic               quiet       = 1'b0;
   logic               req_taken   = 1'b0;
   int                 mismatch_count  = 0;
   int                 words_sent      = 0;
   int                 results_checked = 0;
   int                 settings_used   = 0;
   int                 cycle_count     = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [SYM_W-1:0] digit_code(int unsigned value);
      return SYM_ZERO + SYM_W'(value);
   endfunction

   function automatic logic [SYM_W-1:0] pick_operator();
      int unsigned roll;
      roll = $urandom_range(99);
      // Multiplication is favored so that values grow past the small range
      // and the wrapping paths get exercised.
      if (roll < 30) return SYM_STAR;
      if (roll < 50) return SYM_PLUS;
      if (roll < 70) return SYM_MINUS;
      if (roll < 85) return SYM_SLASH;
      return SYM_PERCENT;
   endfunction

   // Applies one character to the model stack and returns the result word the
   // block must produce for it.
   function automatic result_word_type evaluate_symbol(logic [SYM_W-1:0] sym);
      result_word_type   res;
      logic [DATA_W-1:0] a, b, v, ua, ub, quo, rem;
      int                eff_limit;
      eff_limit = (limit_model > STACK_DEPTH) ? STACK_DEPTH : int'(limit_model);
      res.symbol    = sym;
      res.top_value = '0;
      res.is_final  = 1'b0;
      if (sym == SYM_HASH) begin
         // The end marker reports the depth before the stack is cleared.
         res.depth    = DEPTH_W'(stack_fill);
         res.is_final = 1'b1;
         if (pending_error != STATUS_OK) begin
            res.status = pending_error;
         end else if (stack_fill > 1) begin
            res.status = STATUS_LEFT;
         end else if (stack_fill == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.status    = STATUS_OK;
            res.top_value = model_stack[0];
         end
         stack_fill    = 0;
         pending_error = STATUS_OK;
      end else begin
         // While an error is pending, everything up to the end marker is
         // ignored; characters that are no digit and no operator are too.
         if (pending_error == STATUS_OK) begin
            if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
               if (stack_fill < eff_limit) begin
                  model_stack[stack_fill] = DATA_W'(sym - SYM_ZERO);
                  stack_fill++;
               end else begin
                  pending_error = STATUS_FULL;
               end
            end else if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_STAR ||
                         sym == SYM_SLASH || sym == SYM_PERCENT) begin
               if (stack_fill < 2) begin
                  pending_error = STATUS_EMPTY;
               end else begin
                  b = model_stack[stack_fill-1];
                  a = model_stack[stack_fill-2];
                  if ((sym == SYM_SLASH || sym == SYM_PERCENT) && b == '0) begin
                     pending_error = STATUS_DIVZERO;
                  end else begin
                     case (sym)
                        SYM_PLUS:  v = a + b;
                        SYM_MINUS: v = a - b;
                        SYM_STAR:  v = a * b;
                        default: begin
                           // Divide magnitudes and fix the signs afterwards, so
                           // the most negative value over -1 wraps as in 32-bit
                           // hardware instead of trapping.
                           ua  = a[DATA_W-1] ? -a : a;
                           ub  = b[DATA_W-1] ? -b : b;
                           quo = ua / ub;
                           rem = ua % ub;
                           if (sym == SYM_PERCENT) begin
                              v = a[DATA_W-1] ? -rem : rem;
                           end else begin
                              v = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quo : quo;
                           end
                        end
                     endcase
                     stack_fill--;
                     model_stack[stack_fill-1] = v;
                  end
               end
            end
         end
         res.status    = pending_error;
         res.top_value = (stack_fill == 0) ? '0 : model_stack[stack_fill-1];
         res.depth     = DEPTH_W'(stack_fill);
      end
      return res;
   endfunction

   function automatic void compare_field(string name, logic [SYM_W-1:0] sym,
                                         logic [DATA_W-1:0] want,
                                         logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch on symbol 8'h%02h, expected %0h, actual %0h",
                  $time, name, sym, want, got);
         mismatch_count++;
      end
   endfunction

   // Builds the most negative 32-bit value as 2 * 8^10, then applies / or % with
   // -1 (made as 0 - 1) as divisor; the quotient must wrap. Needs three stack entries.
   task automatic append_min_int_division(logic [SYM_W-1:0] op);
      char_queue.push_back(digit_code(2));
      repeat (10) begin
         char_queue.push_back(digit_code(8));
         char_queue.push_back(SYM_STAR);
      end
      char_queue.push_back(digit_code(0));
      char_queue.push_back(digit_code(1));
      char_queue.push_back(SYM_MINUS);
      char_queue.push_back(op);
      char_queue.push_back(SYM_HASH);
   endtask

   // Appends one expression closed by an end marker. Most are well formed for
   // the current limit so that they reach the arithmetic; the rest are towers
   // that fill the stack, broken sequences and expressions with noise mixed in.
   task automatic append_expression();
      int          eff_limit, depth_now, digits_left, peak;
      int unsigned kind;
      eff_limit = (phase_limit > STACK_DEPTH) ? STACK_DEPTH : int'(phase_limit);
      kind      = $urandom_range(99);
      depth_now = 0;
      if (kind < 8) begin
         // A tower pushes everything first, one past the limit at most, and
         // then folds it back down.
         peak = $urandom_range(eff_limit + 1, 1);
         repeat (peak) char_queue.push_back(digit_code($urandom_range(9)));
         repeat (peak - 1) char_queue.push_back(pick_operator());
      end else if (kind < 11 && eff_limit >= 3) begin
         append_min_int_division($urandom_range(1) ? SYM_SLASH : SYM_PERCENT);
         return;
      end else if (kind < 25) begin
         repeat ($urandom_range(10, 1)) begin
            case ($urandom_range(2))
               0:       char_queue.push_back(digit_code($urandom_range(9)));
               1:       char_queue.push_back(pick_operator());
               default: char_queue.push_back(SYM_W'($urandom_range(255)));
            endcase
         end
      end else begin
         peak = ($urandom_range(7) == 0) ? eff_limit : ((eff_limit < 6) ? eff_limit : 6);
         if (peak < 1) peak = 1;
         digits_left = $urandom_range(2 * peak + 2, 1);
         while (digits_left > 0 || depth_now > 1) begin
            if (kind >= 88 && $urandom_range(9) == 0) begin
               char_queue.push_back(SYM_W'($urandom_range(255)));
            end
            if (digits_left > 0 &&
                (depth_now < 2 || (depth_now < peak && $urandom_range(1) == 1))) begin
               char_queue.push_back(digit_code($urandom_range(9)));
               digits_left--;
               depth_now++;
            end else begin
               char_queue.push_back(pick_operator());
               depth_now--;
            end
         end
      end
      char_queue.push_back(SYM_HASH);
   endtask

   // The block is idle once nothing is waiting to be sent, the request line
   // is low and every expected result word has come back.
   task automatic wait_until_idle();
      while (char_queue.size() != 0 || req_bus.valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // The sender holds off here until the block has drained, which also gives
   // the back pressure case where the pipeline empties completely.
   task automatic write_stack_limit(logic [LIMIT_W-1:0] value);
      wait_until_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      phase_limit = value;
      settings_used++;
      @(posedge clock);
   endtask

   // Sender: a new word goes out at the falling edge only when the line is
   // free or the previous word was taken at the last rising edge.
   always @(negedge clock) begin : driver
      logic send;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         send = (char_queue.size() != 0) && (quiet || $urandom_range(99) >= 16);
         if (send) begin
            req_bus.symbol <= char_queue.pop_front();
            req_bus.valid  <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: ready drops at random about 16 percent of the time, except in quiet phases.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= quiet || ($urandom_range(99) >= 16);
      end
   end

   // Monitor: at each rising edge, register writes update the model limit,
   // an accepted character word is run through the model, and an accepted
   // result word is checked against the oldest expectation. The character is
   // handled first; its own result can never arrive in the same cycle.
   always @(posedge clock) begin : monitor
      result_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (csr_write_enable) limit_model = csr_write_data;
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(evaluate_symbol(req_bus.symbol));
            words_sent++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %0h/%0d/%0d/%0d",
                        $time, rsp_bus.top_value, rsp_bus.status, rsp_bus.depth,
                        rsp_bus.is_final);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("top_value", want.symbol, want.top_value, rsp_bus.top_value);
               compare_field("status", want.symbol, DATA_W'(want.status),
                             DATA_W'(rsp_bus.status));
               compare_field("depth", want.symbol, DATA_W'(want.depth),
                             DATA_W'(rsp_bus.depth));
               compare_field("is_final", want.symbol, DATA_W'(want.is_final),
                             DATA_W'(rsp_bus.is_final));
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int                 random_items;
      int                 phase;
      logic [LIMIT_W-1:0] next_limit;
      logic [LIMIT_W-1:0] limit_plan [8];
      limit_plan = '{6'd20, 6'd2, 6'd32, 6'd1, 6'd63, 6'd5, 6'd0, 6'd12};
      random_items = 0;
      phase        = 0;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Directed words at the reset limit. An empty expression comes first.
      char_queue.push_back(SYM_HASH);
      // 0 - 9 = -9, then -9 / 7 = -1 and -1 % 2 = -1: signed truncation.
      char_queue.push_back(digit_code(0)); char_queue.push_back(digit_code(9));
      char_queue.push_back(SYM_MINUS);
      char_queue.push_back(digit_code(7)); char_queue.push_back(SYM_SLASH);
      char_queue.push_back(digit_code(2)); char_queue.push_back(SYM_PERCENT);
      char_queue.push_back(SYM_HASH);
      // 9 * 8 + 6 = 78.
      char_queue.push_back(digit_code(9)); char_queue.push_back(digit_code(8));
      char_queue.push_back(SYM_STAR);
      char_queue.push_back(digit_code(6)); char_queue.push_back(SYM_PLUS);
      char_queue.push_back(SYM_HASH);
      // A zero divisor, then an operator on an empty stack followed by a digit
      // that the pending error must swallow.
      char_queue.push_back(digit_code(5)); char_queue.push_back(digit_code(0));
      char_queue.push_back(SYM_SLASH); char_queue.push_back(SYM_HASH);
      char_queue.push_back(SYM_PLUS); char_queue.push_back(digit_code(5));
      char_queue.push_back(SYM_HASH);
      // Two values left at the end, with all-ones and all-zeros characters
      // in between that are simply ignored.
      char_queue.push_back(digit_code(1)); char_queue.push_back(digit_code(2));
      char_queue.push_back(8'hFF); char_queue.push_back(8'h00);
      char_queue.push_back(SYM_HASH);

      // A limit above the stack size acts as the full stack: 33 pushes must
      // report a full stack. Then the most negative value over -1, both ways.
      write_stack_limit(6'd63);
      repeat (STACK_DEPTH + 1) char_queue.push_back(digit_code(9));
      char_queue.push_back(SYM_HASH);
      append_min_int_division(SYM_SLASH);
      append_min_int_division(SYM_PERCENT);

      // A one-entry stack fills on the second digit; a zero limit on the first.
      write_stack_limit(6'd1);
      char_queue.push_back(digit_code(1)); char_queue.push_back(digit_code(2));
      char_queue.push_back(SYM_HASH);
      write_stack_limit(6'd0);
      char_queue.push_back(digit_code(5)); char_queue.push_back(SYM_HASH);

      // Random phases, each with its own limit; one runs without any idling.
      while (random_items < RANDOM_ITEMS) begin
         next_limit = (phase < 8) ? limit_plan[phase] : LIMIT_W'($urandom_range(63));
         write_stack_limit(next_limit);
         quiet = (phase == 2);
         while (char_queue.size() < PHASE_ITEMS) append_expression();
         random_items += char_queue.size();
         phase++;
      end

      wait_until_idle();
      quiet = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Evaluated %0d character words into %0d checked result words", words_sent,
               results_checked);
      $display("across %0d stack limit settings, %0d mismatches seen.", settings_used,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
